// ----- hw/rtl/adc_avg_pkg.sv -----
// Shared types and constants for the ADC sample averaging block.
package adc_avg_pkg;

	// Field widths
	localparam int CODE_BITS  = 12;
	localparam int COUNT_BITS = 8;
	localparam int MV_BITS    = 15;

	// Default sample resolution and reset sample count
	localparam int SAMPLE_BITS_DEF = 12;
	localparam logic [COUNT_BITS-1:0] COUNT_RESET = 8'd8;

	// 3300 mV full scale times the divider ratio of 8
	localparam int MV_SCALE_BITS = 15;
	localparam logic [MV_SCALE_BITS-1:0] MV_SCALE = 15'd26400;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL,
		ST_LOAD
	} avg_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic accept;
		logic start_div;
		logic div_step;
		logic mul;
		logic load_out;
	} avg_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic close;
	} avg_sts_t;

endpackage

// ----- hw/rtl/adc_avg_if.sv -----
// Valid/ready channel interfaces for samples and averaged results.
interface adc_avg_sample_if import adc_avg_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] sample_code;

	modport source (output valid, output sample_code, input ready);
	modport sink (input valid, input sample_code, output ready);
endinterface

interface adc_avg_result_if import adc_avg_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] mean_code;
	logic [MV_BITS-1:0]   supply_millivolts;

	modport source (output valid, output mean_code, output supply_millivolts, input ready);
	modport sink (input valid, input mean_code, input supply_millivolts, output ready);
endinterface

// ----- hw/rtl/adc_avg_ctrl.sv -----
// Controller: sequences accumulation, serial division, scaling and result load.
module adc_avg_ctrl import adc_avg_pkg::*; #(
	parameter int DIV_STEPS = SAMPLE_BITS_DEF + COUNT_BITS
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  avg_sts_t sts,
	output avg_cmd_t cmd
);

	localparam int CntBits = $clog2(DIV_STEPS);

	avg_state_t         state_q, state_d;
	logic [CntBits-1:0] step_q;
	logic               out_full_q;
	logic               out_taken;

	assign out_valid = out_full_q;
	assign out_taken = out_full_q && out_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.start_div) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + CntBits'(1);
		end
	end

	// Output holding flag: set on load, cleared when the request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_full_q <= 1'b1;
		end else if (out_taken) begin
			out_full_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.close) begin
						cmd.start_div = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == CntBits'(DIV_STEPS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// wait until the previous result has left
				if (!out_full_q || out_taken) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hw/rtl/adc_avg_dp.sv -----
// Datapath: accumulator, count register, restoring divider, scaler and result register.
module adc_avg_dp import adc_avg_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_BITS-1:0] cfg_wdata,
	input  logic [CODE_BITS-1:0]  sample_code,
	input  avg_cmd_t              cmd,
	output avg_sts_t              sts,
	output logic [CODE_BITS-1:0]  mean_code,
	output logic [MV_BITS-1:0]    supply_millivolts
);

	localparam int SumBits  = SAMPLE_BITS + COUNT_BITS;
	localparam int ProdBits = SumBits + MV_SCALE_BITS;
	localparam logic [CODE_BITS-1:0] CodeMask = CODE_BITS'((32'd1 << SAMPLE_BITS) - 32'd1);

	logic [COUNT_BITS-1:0] count_q;
	logic [SumBits-1:0]    sum_q, sum_next;
	logic [COUNT_BITS-1:0] seen_q, seen_next;
	logic [SumBits-1:0]    quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS:0]   trial, trial_diff;
	logic                  trial_ge;
	logic [ProdBits-1:0]   prod_q;
	logic [CODE_BITS-1:0]  mean_q;
	logic [MV_BITS-1:0]    mv_q;

	// Count register, zero saturates to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= (cfg_wdata == '0) ? COUNT_BITS'(1) : cfg_wdata;
		end
	end

	// Accumulate and decide whether this sample closes the block
	assign sum_next  = sum_q + SumBits'(sample_code & CodeMask);
	assign seen_next = seen_q + COUNT_BITS'(1);
	assign sts.close = (seen_next >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			seen_q <= '0;
		end else if (cmd.accept) begin
			if (cmd.start_div) begin
				sum_q  <= '0;
				seen_q <= '0;
			end else begin
				sum_q  <= sum_next;
				seen_q <= seen_next;
			end
		end
	end

	// Restoring divider, one quotient bit a cycle
	assign trial      = {rem_q, quo_q[SumBits-1]};
	assign trial_diff = trial - {1'b0, count_q};
	assign trial_ge   = (trial >= {1'b0, count_q});

	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			quo_q <= sum_next;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[SumBits-2:0], trial_ge};
		end
	end

	// Scale the mean to millivolts
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= ProdBits'(quo_q) * ProdBits'(MV_SCALE);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			mean_q <= quo_q[CODE_BITS-1:0];
			mv_q   <= prod_q[SAMPLE_BITS+MV_BITS-1:SAMPLE_BITS];
		end
	end

	assign mean_code         = mean_q;
	assign supply_millivolts = mv_q;

endmodule

// ----- hw/rtl/adc_average_to_millivolts_top.sv -----
// Top level of the ADC sample averaging block.
//
// Samples arrive on sample_in as valid/ready requests, one 12-bit code each.
// Each accepted sample is added into a running block sum. When the number of
// samples in the block reaches average_count (written through cfg_we and
// cfg_wdata, zero taken as one, reset value 8), the block sum is divided by
// the count and the mean is scaled to millivolts as mean * 26400 / 4096.
// The result leaves on result_out as one request with mean_code and
// supply_millivolts; the sum and sample counter start again from zero.
// A sample that does not close a block is taken as soon as it is offered. A
// closing sample starts a restoring divider that yields one quotient bit a
// cycle, then a multiply step and a result load step; the load waits while
// an earlier result is still held. The result is shown as intake reopens
// after the load. sample_in.ready is low meanwhile.
// The result sits in an output register, so samples of the next block keep
// flowing while the receiver stalls; only a second result waits for it.
// Reset clears the sum, the counter and any pending result.
module adc_average_to_millivolts_top import adc_avg_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [COUNT_BITS-1:0] cfg_wdata,
	adc_avg_sample_if.sink        sample_in,
	adc_avg_result_if.source      result_out
);

	avg_cmd_t cmd;
	avg_sts_t sts;

	adc_avg_ctrl #(
		.DIV_STEPS (SAMPLE_BITS + COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_in.valid),
		.in_ready  (sample_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	adc_avg_dp #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.sample_code       (sample_in.sample_code),
		.cmd               (cmd),
		.sts               (sts),
		.mean_code         (result_out.mean_code),
		.supply_millivolts (result_out.supply_millivolts)
	);

endmodule

// ----- hw/rtl/adc_avg_chk.sv -----
// Port-level checker for the ADC sample averaging block, with its bind.
module adc_avg_chk import adc_avg_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [CODE_BITS-1:0] mean_code,
	input logic [MV_BITS-1:0]   supply_millivolts
);

	// A stalled result request holds and keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_code)
			&& $stable(supply_millivolts))
		else $error("result request changed while stalled");

	// A new result appears together with sample intake reopening
	a_rose_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result shown while samples still blocked");

	// A new result appears only after intake was blocked
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result shown without computation");

	// Intake only closes after a sample has been taken
	a_fell_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("intake closed without a sample request");

endmodule

bind adc_average_to_millivolts_top adc_avg_chk u_chk (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (sample_in.valid),
	.in_ready          (sample_in.ready),
	.out_valid         (result_out.valid),
	.out_ready         (result_out.ready),
	.mean_code         (result_out.mean_code),
	.supply_millivolts (result_out.supply_millivolts)
);

// ----- tb/adc_average_to_millivolts_top_tb.sv -----
// Self-checking testbench for the ADC sample averaging block: directed table, then random phases.
module adc_average_to_millivolts_top_tb import adc_avg_pkg::*;;

	localparam int HALF_PERIOD   = 10;
	localparam int RESET_CYCLES  = 4;
	localparam int SETTLE_CYCLES = 30;
	localparam int RANDOM_ITEMS  = 1530;
	localparam int LONG_HOLD     = 400;
	localparam int LIMIT_TIME    = 10_000_000;
	localparam int FULL_SCALE_MV = 3300;
	localparam int DIVIDER_RATIO = 8;
	localparam int SUM_BITS      = SAMPLE_BITS_DEF + 8;

	typedef enum logic [1:0] {
		ROW_SAMPLE,
		ROW_CHECKED,
		ROW_CONFIG
	} row_kind_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] mean_code;
		logic [MV_BITS-1:0]   supply_millivolts;
	} average_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [COUNT_BITS-1:0] count_value;
		logic [CODE_BITS-1:0]  code;
		average_t              known;
	} stim_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [COUNT_BITS-1:0] cfg_wdata;

	adc_avg_sample_if sample_bus ();
	adc_avg_result_if result_bus ();

	adc_average_to_millivolts_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sample_in  (sample_bus),
		.result_out (result_bus)
	);

	// Predictor state
	logic [COUNT_BITS-1:0] avg_count;
	logic [SUM_BITS-1:0]   block_sum;
	logic [COUNT_BITS-1:0] block_seen;

	average_t  pending_averages [$];
	stim_row_t stim_rows [$];
	int        fail_count = 0;
	bit        tx_eager = 1'b0;
	bit        rx_eager = 1'b0;
	int        rx_hold_cycles = 0;

	// Clock
	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	// Adds one sample to the running block; returns 1 and the average when the block closes
	function automatic bit average_step(input logic [CODE_BITS-1:0] code, output average_t res);
		logic [31:0] mean;
		logic [31:0] scaled;
		block_sum  = block_sum + SUM_BITS'(code);
		block_seen = block_seen + 1'b1;
		res = '0;
		if (block_seen < avg_count)
			return 1'b0;
		mean   = 32'(block_sum) / 32'(avg_count);
		scaled = mean * (FULL_SCALE_MV * DIVIDER_RATIO);
		res.mean_code         = mean[CODE_BITS-1:0];
		res.supply_millivolts = scaled[SAMPLE_BITS_DEF +: MV_BITS];
		block_sum  = '0;
		block_seen = '0;
		return 1'b1;
	endfunction

	function automatic logic [CODE_BITS-1:0] draw_code();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CODE_BITS'($urandom_range(0, (1 << CODE_BITS) - 1));
		endcase
	endfunction

	function automatic stim_row_t row_sample(input logic [CODE_BITS-1:0] code);
		return '{kind: ROW_SAMPLE, count_value: '0, code: code, known: '0};
	endfunction

	function automatic stim_row_t row_checked(input logic [CODE_BITS-1:0] code,
			input logic [CODE_BITS-1:0] mean, input logic [MV_BITS-1:0] mv);
		return '{kind: ROW_CHECKED, count_value: '0, code: code, known: '{mean, mv}};
	endfunction

	function automatic stim_row_t row_config(input logic [COUNT_BITS-1:0] value);
		return '{kind: ROW_CONFIG, count_value: value, code: '0, known: '0};
	endfunction

	// Offers one sample request after a random gap (none when tx_eager is set) and waits until it is taken
	task automatic send_sample(input logic [CODE_BITS-1:0] code, input bit use_known,
			input average_t known);
		int       gap;
		average_t predicted;
		gap = tx_eager ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			sample_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_bus.valid       <= 1'b1;
		sample_bus.sample_code <= code;
		do @(posedge clk); while (!sample_bus.ready);
		if (average_step(code, predicted))
			pending_averages.push_back(use_known ? known : predicted);
	endtask

	// Writes the count register once every average is out and the divider has settled
	task automatic write_average_count(input logic [COUNT_BITS-1:0] value);
		sample_bus.valid <= 1'b0;
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		avg_count = (value == '0) ? COUNT_BITS'(1) : value;
	endtask

	// Result receiver and checker
	initial begin
		int       stall;
		average_t want;
		result_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_eager ? 0 : $urandom_range(0, 6);
			if (rx_hold_cycles != 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall > 0) begin
				result_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (!result_bus.valid);
			if (pending_averages.size() == 0) begin
				$error("unexpected average: mean_code %0d, supply_millivolts %0d",
					result_bus.mean_code, result_bus.supply_millivolts);
				fail_count++;
			end else begin
				want = pending_averages.pop_front();
				if (result_bus.mean_code !== want.mean_code) begin
					$error("mean_code: expected %0d, actual %0d",
						want.mean_code, result_bus.mean_code);
					fail_count++;
				end
				if (result_bus.supply_millivolts !== want.supply_millivolts) begin
					$error("supply_millivolts: expected %0d, actual %0d",
						want.supply_millivolts, result_bus.supply_millivolts);
					fail_count++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int                    random_sent;
		int                    phase;
		int                    phase_len;
		logic [COUNT_BITS-1:0] next_count;
		stim_row_t             row;

		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_wdata              <= '0;
		sample_bus.valid       <= 1'b0;
		sample_bus.sample_code <= '0;
		avg_count  = COUNT_RESET;
		block_sum  = '0;
		block_seen = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset count of 8 at full scale, the lowest count, zero count,
		// and a count lowered below the samples already taken in the block
		repeat (7) stim_rows.push_back(row_sample(12'd4095));
		stim_rows.push_back(row_checked(12'd4095, 12'd4095, 15'd26393));
		stim_rows.push_back(row_config(8'd1));
		stim_rows.push_back(row_checked(12'd0, 12'd0, 15'd0));
		stim_rows.push_back(row_checked(12'd4095, 12'd4095, 15'd26393));
		stim_rows.push_back(row_config(8'd0));
		stim_rows.push_back(row_checked(12'd2048, 12'd2048, 15'd13200));
		stim_rows.push_back(row_checked(12'd1, 12'd1, 15'd6));
		stim_rows.push_back(row_config(8'd2));
		stim_rows.push_back(row_sample(12'd4095));
		stim_rows.push_back(row_sample(12'd0));
		stim_rows.push_back(row_config(8'd8));
		stim_rows.push_back(row_sample(12'd100));
		stim_rows.push_back(row_sample(12'd200));
		stim_rows.push_back(row_sample(12'd300));
		stim_rows.push_back(row_sample(12'd400));
		stim_rows.push_back(row_sample(12'd500));
		stim_rows.push_back(row_config(8'd3));
		stim_rows.push_back(row_sample(12'd600));
		stim_rows.push_back(row_sample(12'd2730));

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.kind == ROW_CONFIG)
				write_average_count(row.count_value);
			else
				send_sample(row.code, row.kind == ROW_CHECKED, row.known);
		end

		// Random phases, each at its own count; the first ones hit the extremes
		random_sent = 0;
		phase       = 0;
		while (random_sent < RANDOM_ITEMS) begin
			case (phase)
				0: next_count = 8'd255;
				1: next_count = 8'd1;
				2: next_count = 8'd0;
				3: next_count = 8'd2;
				default: begin
					if ($urandom_range(0, 3) == 0)
						next_count = COUNT_BITS'($urandom_range(0, 255));
					else
						next_count = COUNT_BITS'($urandom_range(1, 12));
				end
			endcase
			write_average_count(next_count);
			tx_eager = ($urandom_range(0, 3) == 0);
			rx_eager = ($urandom_range(0, 3) == 0);
			// Long receiver hold with one sample per block, so the block backs up
			if (phase == 1) begin
				tx_eager       = 1'b1;
				rx_hold_cycles = LONG_HOLD;
			end
			phase_len = $urandom_range(40, 120);
			if (phase_len < int'(next_count) + 20)
				phase_len = int'(next_count) + $urandom_range(1, 40);
			// last phase stops at the planned item count
			if (phase_len > RANDOM_ITEMS - random_sent)
				phase_len = RANDOM_ITEMS - random_sent;
			repeat (phase_len) begin
				send_sample(draw_code(), 1'b0, '0);
				random_sent++;
			end
			phase++;
		end

		// Drain
		sample_bus.valid <= 1'b0;
		while (pending_averages.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("adc_average_to_millivolts_top_tb passed");
		else
			$display("adc_average_to_millivolts_top_tb failed");
		$finish;
	end

	// Watchdog
	initial begin
		#LIMIT_TIME;
		$display("adc_average_to_millivolts_top_tb failed");
		$finish;
	end

endmodule
